// File: src/scq_pkg.sv
package scq_pkg;

   localparam int QuatW     = 16;
   localparam int ScaleW    = 16;
   localparam int ProdW     = 2 * QuatW;
   localparam int RotW      = ProdW + 2;
   localparam int ScProdW   = RotW + ScaleW + 1;
   localparam int MW        = 30;
   localparam int CovProdW  = 2 * MW;
   localparam int AccW      = CovProdW + 2;
   localparam int CovW      = 32;
   localparam int FracShift = 20;
   localparam int NumAxes   = 3;
   localparam int NumRot    = NumAxes * NumAxes;
   localparam int NumProd   = 9;
   localparam int NumCov    = 6;

   typedef logic signed [QuatW-1:0]    quat_type;
   typedef logic        [ScaleW-1:0]   scale_type;
   typedef logic signed [ProdW-1:0]    prod_type;
   typedef logic signed [RotW-1:0]     rot_type;
   typedef logic signed [ScProdW-1:0]  scprod_type;
   typedef logic signed [MW-1:0]       mcol_type;
   typedef logic signed [CovProdW-1:0] covprod_type;
   typedef logic signed [CovW-1:0]     cov_type;

   // unity in units of 2^-28
   localparam rot_type RotOne = 34'sh0_1000_0000;

   // quaternion product slots
   localparam int PXX = 0;
   localparam int PYY = 1;
   localparam int PZZ = 2;
   localparam int PXY = 3;
   localparam int PXZ = 4;
   localparam int PYZ = 5;
   localparam int PWX = 6;
   localparam int PWY = 7;
   localparam int PWZ = 8;

   // covariance entries: xx, xy, xz, yy, yz, zz
   localparam int CovRow [NumCov] = '{0, 0, 0, 1, 1, 2};
   localparam int CovCol [NumCov] = '{0, 1, 2, 1, 2, 2};

endpackage

// File: src/scq_req_if.sv
interface scq_req_if;
   import scq_pkg::*;

   logic      valid;
   logic      ready;
   quat_type  quat_w;
   quat_type  quat_x;
   quat_type  quat_y;
   quat_type  quat_z;
   scale_type scale_x;
   scale_type scale_y;
   scale_type scale_z;

   modport source (
      output valid, quat_w, quat_x, quat_y, quat_z, scale_x, scale_y, scale_z,
      input  ready
   );

   modport sink (
      input  valid, quat_w, quat_x, quat_y, quat_z, scale_x, scale_y, scale_z,
      output ready
   );

endinterface

// File: src/scq_rsp_if.sv
interface scq_rsp_if;
   import scq_pkg::*;

   logic    valid;
   logic    ready;
   cov_type cov_xx;
   cov_type cov_xy;
   cov_type cov_xz;
   cov_type cov_yy;
   cov_type cov_yz;
   cov_type cov_zz;

   modport source (
      output valid, cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz,
      input  ready
   );

   modport sink (
      input  valid, cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz,
      output ready
   );

endinterface

// File: src/scq_rotation.sv
module scq_rotation (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  scq_pkg::quat_type   quat_w,
   input  scq_pkg::quat_type   quat_x,
   input  scq_pkg::quat_type   quat_y,
   input  scq_pkg::quat_type   quat_z,
   input  scq_pkg::scale_type  scale_in [scq_pkg::NumAxes],
   output logic                out_valid,
   input  logic                out_ready,
   output scq_pkg::rot_type    rot [scq_pkg::NumRot],
   output scq_pkg::scale_type  scale_out [scq_pkg::NumAxes]
);
   import scq_pkg::*;

   logic      ready_a;
   logic      ready_b;
   logic      v_a_ff, v_a_in;
   logic      v_b_ff, v_b_in;
   prod_type  prod_ff [NumProd];
   prod_type  prod_in [NumProd];
   scale_type sa_ff [NumAxes];
   rot_type   rot_ff [NumRot];
   rot_type   rot_in [NumRot];
   scale_type sb_ff [NumAxes];
   rot_type   ext [NumProd];

   assign ready_b  = !v_b_ff || out_ready;
   assign ready_a  = !v_a_ff || ready_b;
   assign in_ready = ready_a;

   always_comb begin
      v_a_in = ready_a ? in_valid : v_a_ff;
      v_b_in = ready_b ? v_a_ff : v_b_ff;
   end

   // stage a: the nine quaternion products the rotation needs (all but w*w)
   always_comb begin
      prod_in[PXX] = quat_x * quat_x;
      prod_in[PYY] = quat_y * quat_y;
      prod_in[PZZ] = quat_z * quat_z;
      prod_in[PXY] = quat_x * quat_y;
      prod_in[PXZ] = quat_x * quat_z;
      prod_in[PYZ] = quat_y * quat_z;
      prod_in[PWX] = quat_w * quat_x;
      prod_in[PWY] = quat_w * quat_y;
      prod_in[PWZ] = quat_w * quat_z;
   end

   // stage b: rotation entries in units of 2^-28
   always_comb begin
      for (int n = 0; n < NumProd; n++) begin
         ext[n] = RotW'(prod_ff[n]);
      end
      rot_in[0] = RotOne - ((ext[PYY] + ext[PZZ]) <<< 1);
      rot_in[1] = (ext[PXY] - ext[PWZ]) <<< 1;
      rot_in[2] = (ext[PXZ] + ext[PWY]) <<< 1;
      rot_in[3] = (ext[PXY] + ext[PWZ]) <<< 1;
      rot_in[4] = RotOne - ((ext[PXX] + ext[PZZ]) <<< 1);
      rot_in[5] = (ext[PYZ] - ext[PWX]) <<< 1;
      rot_in[6] = (ext[PXZ] - ext[PWY]) <<< 1;
      rot_in[7] = (ext[PYZ] + ext[PWX]) <<< 1;
      rot_in[8] = RotOne - ((ext[PXX] + ext[PYY]) <<< 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff <= 1'b0;
         v_b_ff <= 1'b0;
      end else begin
         v_a_ff <= v_a_in;
         v_b_ff <= v_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a && in_valid) begin
         prod_ff <= prod_in;
         sa_ff   <= scale_in;
      end
      if (ready_b && v_a_ff) begin
         rot_ff <= rot_in;
         sb_ff  <= sa_ff;
      end
   end

   assign out_valid = v_b_ff;
   assign rot       = rot_ff;
   assign scale_out = sb_ff;

endmodule

// File: src/scq_scale.sv
module scq_scale (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  scq_pkg::rot_type    rot [scq_pkg::NumRot],
   input  scq_pkg::scale_type  scale [scq_pkg::NumAxes],
   output logic                out_valid,
   input  logic                out_ready,
   output scq_pkg::mcol_type   m [scq_pkg::NumRot]
);
   import scq_pkg::*;

   localparam scprod_type Bias = ScProdW'(1) <<< (FracShift - 1);

   logic       ready_a;
   logic       ready_b;
   logic       v_a_ff, v_a_in;
   logic       v_b_ff, v_b_in;
   scprod_type p_ff [NumRot];
   scprod_type p_in [NumRot];
   mcol_type   m_ff [NumRot];
   mcol_type   m_in [NumRot];

   assign ready_b  = !v_b_ff || out_ready;
   assign ready_a  = !v_a_ff || ready_b;
   assign in_ready = ready_a;

   always_comb begin
      v_a_in = ready_a ? in_valid : v_a_ff;
      v_b_in = ready_b ? v_a_ff : v_b_ff;
   end

   // scale each column by its axis
   always_comb begin
      for (int i = 0; i < NumAxes; i++) begin
         for (int k = 0; k < NumAxes; k++) begin
            p_in[i*NumAxes+k] = rot[i*NumAxes+k] * $signed({1'b0, scale[k]});
         end
      end
   end

   // round half up back to units of 2^-20
   always_comb begin
      for (int n = 0; n < NumRot; n++) begin
         m_in[n] = MW'((p_ff[n] + Bias) >>> FracShift);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff <= 1'b0;
         v_b_ff <= 1'b0;
      end else begin
         v_a_ff <= v_a_in;
         v_b_ff <= v_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a && in_valid) begin
         p_ff <= p_in;
      end
      if (ready_b && v_a_ff) begin
         m_ff <= m_in;
      end
   end

   assign out_valid = v_b_ff;
   assign m         = m_ff;

endmodule

// File: src/scq_cov.sv
module scq_cov (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  scq_pkg::mcol_type  m [scq_pkg::NumRot],
   output logic               out_valid,
   input  logic               out_ready,
   output scq_pkg::cov_type   cov [scq_pkg::NumCov]
);
   import scq_pkg::*;

   localparam int NumTerm = NumCov * NumAxes;
   localparam int RndW    = AccW - FracShift;
   localparam logic signed [AccW-1:0] Bias  = AccW'(1) <<< (FracShift - 1);
   localparam logic signed [RndW-1:0] SatHi = RndW'(64'sh7fff_ffff);
   localparam logic signed [RndW-1:0] SatLo = RndW'(-64'sh8000_0000);

   logic                    ready_a;
   logic                    ready_b;
   logic                    v_a_ff, v_a_in;
   logic                    v_b_ff, v_b_in;
   covprod_type             q_ff [NumTerm];
   covprod_type             q_in [NumTerm];
   cov_type                 cov_ff [NumCov];
   cov_type                 cov_in [NumCov];
   logic signed [AccW-1:0]  acc [NumCov];
   logic signed [RndW-1:0]  rnd [NumCov];

   assign ready_b  = !v_b_ff || out_ready;
   assign ready_a  = !v_a_ff || ready_b;
   assign in_ready = ready_a;

   always_comb begin
      v_a_in = ready_a ? in_valid : v_a_ff;
      v_b_in = ready_b ? v_a_ff : v_b_ff;
   end

   // row-by-row products of the scaled matrix
   always_comb begin
      for (int e = 0; e < NumCov; e++) begin
         for (int k = 0; k < NumAxes; k++) begin
            q_in[e*NumAxes+k] = m[CovRow[e]*NumAxes+k] * m[CovCol[e]*NumAxes+k];
         end
      end
   end

   // sum the three terms, round half up, clamp to 32 bits
   always_comb begin
      for (int e = 0; e < NumCov; e++) begin
         acc[e] = AccW'(q_ff[e*NumAxes]) + AccW'(q_ff[e*NumAxes+1])
                + AccW'(q_ff[e*NumAxes+2]);
         rnd[e] = RndW'((acc[e] + Bias) >>> FracShift);
         if (rnd[e] > SatHi) begin
            cov_in[e] = CovW'(SatHi);
         end else if (rnd[e] < SatLo) begin
            cov_in[e] = CovW'(SatLo);
         end else begin
            cov_in[e] = CovW'(rnd[e]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff <= 1'b0;
         v_b_ff <= 1'b0;
      end else begin
         v_a_ff <= v_a_in;
         v_b_ff <= v_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a && in_valid) begin
         q_ff <= q_in;
      end
      if (ready_b && v_a_ff) begin
         cov_ff <= cov_in;
      end
   end

   assign out_valid = v_b_ff;
   assign cov       = cov_ff;

   a_out_from_prev: assert property (@(posedge clock) disable iff (reset)
      $rose(v_b_ff) |-> $past(v_a_ff))
      else $error("result stage filled without an item in the product stage");

   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      v_a_ff && !ready_b |=> v_a_ff)
      else $error("product stage dropped an item while blocked");

   a_diag_nonneg: assert property (@(posedge clock) disable iff (reset)
      v_b_ff |-> !cov_ff[0][CovW-1] && !cov_ff[3][CovW-1] && !cov_ff[5][CovW-1])
      else $error("diagonal covariance entry is negative");

endmodule

// File: src/splat_covariance_from_quat_scale_top.sv
// Covariance of a Gaussian splat from its rotation quaternion and axis scales.
//
// req_ch carries one splat per item: quat_w/x/y/z as signed Q2.14 and
// scale_x/y/z as unsigned Q4.12. The quaternion is used as given, without
// normalisation. rsp_ch returns the six distinct entries of R*diag(s^2)*R^T
// as signed Q12.20, each rounded half up and clamped to 32 bits.
//
// An accepted item passes through six register stages before its result is
// valid on rsp_ch: quaternion products, rotation entries, column scaling,
// rounding, row products, sum and clamp. One item is accepted per cycle
// while req_ch.ready is high.
//
// Each stage holds its own valid bit and moves on when the next stage is
// empty or moving, so a stall on rsp_ch.ready fills empty stages first and
// reaches req_ch.ready only when all six stages hold items. Nothing is lost
// or repeated under stall.
//
// Reset is synchronous and clears the valid bits only; the block keeps no
// state between items and needs no warm-up after reset.
module splat_covariance_from_quat_scale_top (
   input logic clock,
   input logic reset,
   scq_req_if.sink   req_ch,
   scq_rsp_if.source rsp_ch
);
   import scq_pkg::*;

   scale_type sc_in [NumAxes];
   scale_type sc_rot [NumAxes];
   rot_type   rot [NumRot];
   mcol_type  m [NumRot];
   cov_type   cov [NumCov];
   logic      rot_valid, rot_ready;
   logic      m_valid, m_ready;

   assign sc_in[0] = req_ch.scale_x;
   assign sc_in[1] = req_ch.scale_y;
   assign sc_in[2] = req_ch.scale_z;

   scq_rotation u_rotation (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .quat_w    (req_ch.quat_w),
      .quat_x    (req_ch.quat_x),
      .quat_y    (req_ch.quat_y),
      .quat_z    (req_ch.quat_z),
      .scale_in  (sc_in),
      .out_valid (rot_valid),
      .out_ready (rot_ready),
      .rot       (rot),
      .scale_out (sc_rot)
   );

   scq_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rot_valid),
      .in_ready  (rot_ready),
      .rot       (rot),
      .scale     (sc_rot),
      .out_valid (m_valid),
      .out_ready (m_ready),
      .m         (m)
   );

   scq_cov u_cov (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m_valid),
      .in_ready  (m_ready),
      .m         (m),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .cov       (cov)
   );

   assign rsp_ch.cov_xx = cov[0];
   assign rsp_ch.cov_xy = cov[1];
   assign rsp_ch.cov_xz = cov[2];
   assign rsp_ch.cov_yy = cov[3];
   assign rsp_ch.cov_yz = cov[4];
   assign rsp_ch.cov_zz = cov[5];

endmodule
